### hw/rtl/adm_ctl_pkg.sv
`default_nettype none

package adm_ctl_pkg;

    // Number of controlled axes; at most NUM_FIELDS of them are computed.
    localparam int AXES       = 3;
    localparam int NUM_FIELDS = 3;
    localparam int LANES      = (AXES < NUM_FIELDS) ? AXES : NUM_FIELDS;
    localparam int AXIS_W     = (LANES > 1) ? $clog2(LANES) : 1;

    // Field and register widths.
    localparam int Q_W       = 32;
    localparam int DT_W      = 16;
    localparam int COEF_W    = 16;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;

    // Datapath widths: the exact sum spring + force - damping fits in 35 bits,
    // the multiplier takes it against a 17-bit signed coefficient.
    localparam int SUM_W  = Q_W + 3;
    localparam int MULB_W = DT_W + 1;
    localparam int PROD_W = SUM_W + MULB_W;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_INV_MASS  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS = CFG_IDX_W'(2);

    // All three coefficients at 1.0 in Q8.8.
    localparam logic [CFG_W-1:0] CFG_RESET = 48'h0100_0100_0100;

    typedef logic signed [Q_W-1:0]    t_q16;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [PROD_W-1:0] t_wide;

    localparam t_wide WIDE_MAX = t_wide'(64'sd2147483647);
    localparam t_wide WIDE_MIN = t_wide'(-64'sd2147483648);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // One datapath operation per cycle, in the order they run for an axis.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_FDT,
        OP_POS,
        OP_DIFF,
        OP_MUL_K,
        OP_SPRING,
        OP_MUL_C,
        OP_DAMP,
        OP_MUL_M,
        OP_ACC,
        OP_MUL_DT,
        OP_VEL
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [AXIS_W-1:0] axis;
        logic              load_in;
        logic              load_out;
    } t_cmd;

    // Round to nearest with ties upwards, then arithmetic shift right.
    function automatic t_wide round_shr(t_wide v, int unsigned sh);
        t_wide half;
        half = t_wide'(1) <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    // Clamp to the signed 32-bit range.
    function automatic t_q16 sat32(t_wide v);
        t_q16 res;
        if (v > WIDE_MAX) begin
            res = t_q16'(WIDE_MAX);
        end else if (v < WIDE_MIN) begin
            res = t_q16'(WIDE_MIN);
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/adm_ctl_ctrl.sv
`default_nettype none

module adm_ctl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output adm_ctl_pkg::t_cmd o_cmd
);
    import adm_ctl_pkg::*;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic [AXIS_W-1:0] r_axis, n_axis;
    logic              r_out_valid, n_out_valid;
    logic              out_free;
    logic              last_axis;

    // Sequence of operations for one axis.
    function automatic t_op next_op(t_op op);
        t_op res;
        unique case (op)
            OP_MUL_FDT: res = OP_POS;
            OP_POS:     res = OP_DIFF;
            OP_DIFF:    res = OP_MUL_K;
            OP_MUL_K:   res = OP_SPRING;
            OP_SPRING:  res = OP_MUL_C;
            OP_MUL_C:   res = OP_DAMP;
            OP_DAMP:    res = OP_MUL_M;
            OP_MUL_M:   res = OP_ACC;
            OP_ACC:     res = OP_MUL_DT;
            OP_MUL_DT:  res = OP_VEL;
            OP_VEL:     res = OP_MUL_FDT;
            default:    res = OP_NONE;
        endcase
        return res;
    endfunction

    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_axis = (r_axis == AXIS_W'(LANES - 1));

    // Next state.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_axis      = r_axis;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_RUN;
                    n_op    = OP_MUL_FDT;
                    n_axis  = '0;
                end
            end
            ST_RUN: begin
                if (r_op == OP_VEL) begin
                    n_op = OP_MUL_FDT;
                    if (last_axis) begin
                        n_state = ST_DONE;
                    end else begin
                        n_axis = r_axis + AXIS_W'(1);
                    end
                end else begin
                    n_op = next_op(r_op);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs towards the ports and the datapath.
    always_comb begin
        o_in_stall     = (r_state != ST_IDLE);
        o_out_valid    = r_out_valid;
        o_cmd.op       = (r_state == ST_RUN) ? r_op : OP_NONE;
        o_cmd.axis     = r_axis;
        o_cmd.load_in  = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.load_out = (r_state == ST_DONE) && out_free;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_NONE;
            r_axis      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_op        <= n_op;
            r_axis      <= n_axis;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/adm_ctl_dpath.sv
`default_nettype none

module adm_ctl_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  adm_ctl_pkg::t_cmd                    i_cmd,
    input  logic                                 i_cfg_we,
    input  logic [adm_ctl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [adm_ctl_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic signed [adm_ctl_pkg::Q_W-1:0]   i_pos_x,
    input  logic signed [adm_ctl_pkg::Q_W-1:0]   i_pos_y,
    input  logic signed [adm_ctl_pkg::Q_W-1:0]   i_heading,
    input  logic signed [adm_ctl_pkg::Q_W-1:0]   i_force_x,
    input  logic signed [adm_ctl_pkg::Q_W-1:0]   i_force_y,
    input  logic signed [adm_ctl_pkg::Q_W-1:0]   i_torque_z,
    input  logic [adm_ctl_pkg::DT_W-1:0]         i_tick_time,
    output logic signed [adm_ctl_pkg::Q_W-1:0]   o_vel_x,
    output logic signed [adm_ctl_pkg::Q_W-1:0]   o_vel_y,
    output logic signed [adm_ctl_pkg::Q_W-1:0]   o_yaw_rate
);
    import adm_ctl_pkg::*;

    // Latched input word.
    t_q16              r_meas [LANES];
    t_q16              r_force[LANES];
    logic [DT_W-1:0]   r_dt;

    // Controller state per axis and working registers.
    t_q16              r_pos[LANES];
    t_q16              r_vel[LANES];
    t_q16              r_tmp;
    t_sum              r_sum;
    t_wide             r_prod;
    t_q16              r_out[NUM_FIELDS];

    // Configuration registers.
    logic [CFG_W-1:0]  r_inv_mass;
    logic [CFG_W-1:0]  r_damping;
    logic [CFG_W-1:0]  r_stiff;

    t_q16              in_meas [NUM_FIELDS];
    t_q16              in_force[NUM_FIELDS];
    logic [COEF_W-1:0] coef_m[LANES];
    logic [COEF_W-1:0] coef_c[LANES];
    logic [COEF_W-1:0] coef_k[LANES];
    t_q16              vel_full[NUM_FIELDS];

    t_q16              meas_s, force_s, pos_s, vel_s;
    logic [COEF_W-1:0] m_s, c_s, k_s;
    t_sum              mul_a;
    logic signed [MULB_W-1:0] mul_b;
    t_wide             mul_p;
    t_wide             rnd8, rnd16;
    t_q16              sat8, pos_upd, vel_upd, diff;
    t_sum              spring_sum, damp_sum;

    assign in_meas[0]  = i_pos_x;
    assign in_meas[1]  = i_pos_y;
    assign in_meas[2]  = i_heading;
    assign in_force[0] = i_force_x;
    assign in_force[1] = i_force_y;
    assign in_force[2] = i_torque_z;

    // Unpack the per-axis Q8.8 coefficients.
    for (genvar g = 0; g < LANES; g++) begin : g_coef
        assign coef_m[g] = r_inv_mass[COEF_W*g +: COEF_W];
        assign coef_c[g] = r_damping[COEF_W*g +: COEF_W];
        assign coef_k[g] = r_stiff[COEF_W*g +: COEF_W];
    end

    // Result fields: computed axes carry their velocity, missing ones read zero.
    for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_vel
        if (g < LANES) begin : g_axis
            assign vel_full[g] = r_vel[g];
        end else begin : g_none
            assign vel_full[g] = '0;
        end
    end

    // Values of the axis being worked on.
    assign meas_s  = r_meas[i_cmd.axis];
    assign force_s = r_force[i_cmd.axis];
    assign pos_s   = r_pos[i_cmd.axis];
    assign vel_s   = r_vel[i_cmd.axis];
    assign m_s     = coef_m[i_cmd.axis];
    assign c_s     = coef_c[i_cmd.axis];
    assign k_s     = coef_k[i_cmd.axis];

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            OP_MUL_FDT: begin
                mul_a = t_sum'(force_s);
                mul_b = signed'({1'b0, r_dt});
            end
            OP_MUL_K: begin
                mul_a = t_sum'(r_tmp);
                mul_b = signed'({1'b0, k_s});
            end
            OP_MUL_C: begin
                mul_a = t_sum'(vel_s);
                mul_b = signed'({1'b0, c_s});
            end
            OP_MUL_M: begin
                mul_a = r_sum;
                mul_b = signed'({1'b0, m_s});
            end
            OP_MUL_DT: begin
                mul_a = t_sum'(r_tmp);
                mul_b = signed'({1'b0, r_dt});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Post-processing of the registered product and the position difference.
    assign rnd8       = round_shr(r_prod, 8);
    assign rnd16      = round_shr(r_prod, 16);
    assign sat8       = sat32(rnd8);
    assign pos_upd    = sat32(t_wide'(pos_s) + rnd16);
    assign vel_upd    = sat32(t_wide'(vel_s) + rnd16);
    assign diff       = sat32(t_wide'(pos_s) - t_wide'(meas_s));
    assign spring_sum = t_sum'(sat8) + t_sum'(force_s);
    assign damp_sum   = r_sum - t_sum'(sat8);

    // Configuration and per-axis state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass <= CFG_RESET;
            r_damping  <= CFG_RESET;
            r_stiff    <= CFG_RESET;
            for (int i = 0; i < LANES; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_INV_MASS:  r_inv_mass <= i_cfg_data;
                    CFG_DAMPING:   r_damping  <= i_cfg_data;
                    CFG_STIFFNESS: r_stiff    <= i_cfg_data;
                    default:       ;
                endcase
            end
            if (i_cmd.op == OP_POS) begin
                r_pos[i_cmd.axis] <= pos_upd;
            end
            if (i_cmd.op == OP_VEL) begin
                r_vel[i_cmd.axis] <= vel_upd;
            end
        end
    end

    // Input latch, working registers and result word.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            for (int i = 0; i < LANES; i++) begin
                r_meas[i]  <= in_meas[i];
                r_force[i] <= in_force[i];
            end
            r_dt <= i_tick_time;
        end
        unique case (i_cmd.op)
            OP_MUL_FDT, OP_MUL_K, OP_MUL_C, OP_MUL_M, OP_MUL_DT: r_prod <= mul_p;
            OP_DIFF:   r_tmp <= diff;
            OP_ACC:    r_tmp <= sat8;
            OP_SPRING: r_sum <= spring_sum;
            OP_DAMP:   r_sum <= damp_sum;
            default:   ;
        endcase
        if (i_cmd.load_out) begin
            for (int i = 0; i < NUM_FIELDS; i++) begin
                r_out[i] <= vel_full[i];
            end
        end
    end

    assign o_vel_x    = r_out[0];
    assign o_vel_y    = r_out[1];
    assign o_yaw_rate = r_out[2];

endmodule

`default_nettype wire

### hw/rtl/admittance_control_step_core.sv
// The input stalls from acceptance until the result word is loaded for output,
// so a new word waits for the last one. Each axis takes 11 steps through the one
// shared 35x17 multiplier and its rounding/saturation stage, three axes in turn.
// A new input word is taken while the previous result still waits at the output.
// Reset (synchronous, active low) clears desired position and velocity to zero
// and sets every inverse mass, damping and stiffness coefficient to 1.0.
`default_nettype none

module admittance_control_step_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [adm_ctl_pkg::Q_W-1:0]   i_pos_x,
    input  logic signed [adm_ctl_pkg::Q_W-1:0]   i_pos_y,
    input  logic signed [adm_ctl_pkg::Q_W-1:0]   i_heading,
    input  logic signed [adm_ctl_pkg::Q_W-1:0]   i_force_x,
    input  logic signed [adm_ctl_pkg::Q_W-1:0]   i_force_y,
    input  logic signed [adm_ctl_pkg::Q_W-1:0]   i_torque_z,
    input  logic [adm_ctl_pkg::DT_W-1:0]         i_tick_time,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [adm_ctl_pkg::Q_W-1:0]   o_vel_x,
    output logic signed [adm_ctl_pkg::Q_W-1:0]   o_vel_y,
    output logic signed [adm_ctl_pkg::Q_W-1:0]   o_yaw_rate,
    input  logic                                 i_cfg_we,
    input  logic [adm_ctl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [adm_ctl_pkg::CFG_W-1:0]        i_cfg_data
);
    import adm_ctl_pkg::*;

    t_cmd cmd;

    // Sequencer.
    adm_ctl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // Arithmetic, state and configuration registers.
    adm_ctl_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_heading   (i_heading),
        .i_force_x   (i_force_x),
        .i_force_y   (i_force_y),
        .i_torque_z  (i_torque_z),
        .i_tick_time (i_tick_time),
        .o_vel_x     (o_vel_x),
        .o_vel_y     (o_vel_y),
        .o_yaw_rate  (o_yaw_rate)
    );

    // An accepted word closes the input until its result is handed over.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting a word");

    // A new result only appears after the datapath loaded the output register.
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.load_out))
        else $error("result valid without an output load");

    // The output register is never overwritten while a result is still held.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("output register loaded while stalled");

    // Datapath operations run only while an item is in work.
    a_op_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op != OP_NONE) |-> (o_in_stall && !cmd.load_in))
        else $error("datapath operation outside an item");

endmodule

`default_nettype wire
